// File: design/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared sizes, item kinds and queue types for the ring-buffer FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

  localparam int MAX_TAPS     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;

  localparam int PTR_W   = $clog2(MAX_TAPS);
  localparam int CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int ACC_W   = 2 * SAMPLE_WIDTH + $clog2(MAX_TAPS) + 1;

  localparam int KIND_W      = 2;
  localparam int COEF_IDX_W  = 6;
  localparam int TAP_CNT_W   = 7;
  localparam int IN_FIELDS_W = 2 * SAMPLE_WIDTH + COEF_IDX_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PUSH    = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [PTR_W-1:0]               coef_addr;
    logic                           coef_ok;
    logic signed [SAMPLE_WIDTH-1:0] coef;
  } fir_op_t;

  typedef struct packed {
    logic    valid;
    fir_op_t op;
  } fir_queue_t;

endpackage

`default_nettype wire

// File: design/fir_ram.sv
// ----------------------------------------------------------------------------
// fir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/fir_front.sv
// ----------------------------------------------------------------------------
// fir_front
// Input side: decodes each item and parks it in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_front
  import fir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,  // sample_in, coef_index, coef_value
  input  wire logic [KIND_W-1:0]     s_tuser,  // kind
  output fir_queue_t                 q,
  input  wire logic                  pop
);

  fir_op_t          q_mem [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;
  fir_op_t          op_in;
  logic             push;
  logic             take;

  // decode / classify
  always_comb begin
    op_in.kind      = kind_t'(s_tuser);
    op_in.sample    = s_tdata[SAMPLE_WIDTH-1:0];
    op_in.coef_addr = PTR_W'(s_tdata[SAMPLE_WIDTH +: COEF_IDX_W]);
    op_in.coef_ok   = 32'(s_tdata[SAMPLE_WIDTH +: COEF_IDX_W]) < 32'(MAX_TAPS);
    op_in.coef      = s_tdata[SAMPLE_WIDTH + COEF_IDX_W +: SAMPLE_WIDTH];
  end

  assign s_tready = (count != QC_W'(Q_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign take     = pop && (count != '0);
  assign q.valid  = (count != '0);
  assign q.op     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/fir_back.sv
// ----------------------------------------------------------------------------
// fir_back
// Execution side: coefficient and history writes, history clear, and the
// shared multiply-accumulate with rounding, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_back
  import fir_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire fir_queue_t              q,
  output logic                         pop,
  input  wire logic [TAP_CNT_W-1:0]    tap_count,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic      [OUT_TDATA_W-1:0]  m_tdata,  // filtered_sample
  output logic                         m_tuser   // saturated
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND
  } state_t;

  localparam int SH_W = ACC_W - FRAC_BITS;
  localparam logic signed [SH_W-1:0] HI =
    {{(SH_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] LO =
    {{(SH_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  state_t                             state;
  logic [PTR_W-1:0]                   wp;
  logic [MAX_TAPS-1:0]                hist_valid;
  logic [CNT_W-1:0]                   k;
  logic [CNT_W-1:0]                   n_eff;
  logic [PTR_W-1:0]                   pos;
  logic                               rd_v;
  logic                               rd_hv;
  logic                               mul_v;
  logic signed [2*SAMPLE_WIDTH-1:0]   prod;
  logic signed [ACC_W-1:0]            acc;

  logic                               coef_we;
  logic                               hist_we;
  logic [SAMPLE_WIDTH-1:0]            coef_rdata;
  logic [SAMPLE_WIDTH-1:0]            hist_rdata;
  logic signed [SAMPLE_WIDTH-1:0]     hist_word;
  logic [CNT_W-1:0]                   n_cfg;
  logic                               issue;
  logic signed [ACC_W-1:0]            rnd;
  logic signed [SH_W-1:0]             shifted;
  logic signed [SAMPLE_WIDTH-1:0]     y;
  logic                               sat;

  assign pop     = (state == ST_IDLE) && q.valid;
  assign coef_we = pop && (q.op.kind == KIND_LOAD) && q.op.coef_ok;
  assign hist_we = pop && (q.op.kind == KIND_PUSH);
  assign issue   = (state == ST_MAC) && (k < n_eff);

  // tap count: zero acts as one, above the built size acts as the built size
  always_comb begin
    if (tap_count == '0) begin
      n_cfg = CNT_W'(1);
    end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
      n_cfg = CNT_W'(MAX_TAPS);
    end else begin
      n_cfg = CNT_W'(tap_count);
    end
  end

  fir_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (q.op.coef_addr),
    .wdata (q.op.coef),
    .raddr (k[PTR_W-1:0]),
    .rdata (coef_rdata)
  );

  fir_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp),
    .wdata (q.op.sample),
    .raddr (pos),
    .rdata (hist_rdata)
  );

  // slots never pushed since the last clear read as zero
  assign hist_word = rd_hv ? $signed(hist_rdata) : '0;

  // round half up, then clamp to Q1.15
  always_comb begin
    rnd     = acc + HALF;
    shifted = SH_W'(rnd >>> FRAC_BITS);
    if (shifted > HI) begin
      y   = HI[SAMPLE_WIDTH-1:0];
      sat = 1'b1;
    end else if (shifted < LO) begin
      y   = LO[SAMPLE_WIDTH-1:0];
      sat = 1'b1;
    end else begin
      y   = shifted[SAMPLE_WIDTH-1:0];
      sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      hist_valid <= '0;
      rd_v       <= 1'b0;
      mul_v      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // MAC pipeline: read -> multiply -> accumulate
      rd_v  <= issue;
      rd_hv <= hist_valid[pos];
      mul_v <= rd_v;
      prod  <= $signed(coef_rdata) * hist_word;
      if (mul_v) begin
        acc <= acc + ACC_W'(prod);
      end

      // ST_ROUND loads the next item itself
      if (m_tready && (state != ST_ROUND)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (q.valid) begin
            case (q.op.kind)
              KIND_PUSH: begin
                hist_valid[wp] <= 1'b1;
                wp <= (wp == PTR_W'(MAX_TAPS - 1)) ? '0 : wp + 1'b1;
              end
              KIND_CLEAR: begin
                hist_valid <= '0;
                wp         <= '0;
              end
              KIND_COMPUTE: begin
                k     <= '0;
                n_eff <= n_cfg;
                pos   <= (wp == '0) ? PTR_W'(MAX_TAPS - 1) : wp - 1'b1;
                acc   <= '0;
                state <= ST_MAC;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAC: begin
          if (issue) begin
            k   <= k + 1'b1;
            pos <= (pos == '0) ? PTR_W'(MAX_TAPS - 1) : pos - 1'b1;
          end else if (!rd_v && !mul_v) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA_W'($unsigned(y));
            m_tuser  <= sat;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/fir_filter_ring_buffer.sv
// ----------------------------------------------------------------------------
// fir_filter_ring_buffer
// Direct-form FIR filter with coefficient RAM and circular sample history.
// ----------------------------------------------------------------------------
// Each input item carries a kind in s_tuser: load coefficient, push sample,
// compute output, or clear history. Only a compute produces an output item:
// the Q1.15 sum over the taps in use of coefficient k times the sample k
// pushes back (newest sample meets coefficient 0), rounded half up and
// clamped, with m_tuser flagging a clamp. A front end decodes items into a
// two-entry queue; the back end executes them one at a time. Load, push and
// clear finish in the idle state (clear resets per-slot valid bits, so there
// is no sweep over the history RAM). In a compute over n effective taps, one
// shared multiply-accumulate reads one coefficient and one history word per
// cycle from the two RAMs, then come a three-stage read/multiply/add drain
// and a rounding state. The queue lets new items arrive while a compute runs.
// tap_count is written through cfg_valid/cfg_data; the user must do so only
// while the block is idle, which the block does not enforce; 0 acts as 1 and
// values above the built size act as the built size. Coefficients must be
// loaded before a compute reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_ring_buffer
  import fir_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input items
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sample_in, coef_index, coef_value
  input  wire logic [KIND_W-1:0]      s_tuser,   // kind
  // result items
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // filtered_sample
  output logic                        m_tuser,   // saturated
  // tap_count register write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [TAP_CNT_W-1:0]   cfg_data   // tap_count
);

  fir_queue_t             q;
  logic                   pop;
  logic [TAP_CNT_W-1:0]   tap_count;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_CNT_W'(MAX_TAPS);
    end else if (cfg_valid) begin
      tap_count <= cfg_data;
    end
  end

  fir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q        (q),
    .pop      (pop)
  );

  fir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q         (q),
    .pop       (pop),
    .tap_count (tap_count),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// File: design/fir_checker.sv
// ----------------------------------------------------------------------------
// fir_checker
// Port-level checks on the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_checker
  import fir_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,   // filtered_sample
  input wire logic                   m_tuser    // saturated
);

  localparam logic [SAMPLE_WIDTH-1:0] POS_FULL = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] NEG_FULL = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[SAMPLE_WIDTH-1:0] == POS_FULL || m_tdata[SAMPLE_WIDTH-1:0] == NEG_FULL))
    else $error("saturation flag without a full-scale output");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item present right after reset");

endmodule

bind fir_filter_ring_buffer fir_checker u_fir_checker (.*);

`default_nettype wire

// File: sim/tb_fir_filter_ring_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fir_filter_ring_buffer
// Self-checking bench for the ring-buffer FIR filter.
// ----------------------------------------------------------------------------
// A short directed sequence hits the Q1.15 extremes, rounding at one half and
// saturation at both ends. Random phases follow, each with a set tap count
// (0 and out-of-range values included) and an idle/stall pattern. A
// scoreboard class keeps a private copy of coefficients, history and write
// pointer, predicts every compute output and checks results in order.
// ----------------------------------------------------------------------------

module tb_fir_filter_ring_buffer;
  import fir_pkg::*;

  localparam int  SMP_LSB        = 0;
  localparam int  IDX_LSB        = SAMPLE_WIDTH;
  localparam int  CV_LSB         = SAMPLE_WIDTH + COEF_IDX_W;
  localparam int  N_PHASES       = 10;
  localparam int  PHASE_ITEMS    = 133;
  localparam int  DRAIN_CYCLES   = 16;    // queue plus MAC drain, with margin
  localparam int  WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam int  MAX_PRINTED    = 100;
  localparam longint Q_MAX       = (longint'(1) <<< FRAC_BITS) - 1;
  localparam longint Q_MIN       = -Q_MAX - 1;

  typedef struct {
    logic [SAMPLE_WIDTH-1:0] value;
    logic                    sat;
  } fir_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: filter predictor plus the queue of pending outputs
  // --------------------------------------------------------------------------
  class fir_scoreboard;
    logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist     [MAX_TAPS];
    logic [PTR_W-1:0]               wr_ptr;
    logic [TAP_CNT_W-1:0]           taps;
    fir_result_t                    pending_q[$];
    int errors, accepted, computes, sat_seen, checked;

    function new();
      foreach (hist[i]) begin
        hist[i]     = '0;
        coef_mem[i] = '0;
      end
      wr_ptr = '0;
      taps   = 7'd64;
    endfunction

    function void set_taps(logic [TAP_CNT_W-1:0] v);
      taps = v;
    endfunction

    function int eff_taps();
      if (taps == 0) return 1;
      if (taps > MAX_TAPS) return MAX_TAPS;
      return int'(taps);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // dot product of coefficients with history, newest sample first
    function fir_result_t filter_output();
      longint           acc;
      longint           y;
      logic [PTR_W-1:0] pos;
      fir_result_t      r;
      int               n;
      n   = eff_taps();
      pos = wr_ptr - 1'b1;
      acc = 0;
      for (int k = 0; k < n; k++) begin
        acc += longint'(coef_mem[k]) * longint'(hist[pos]);
        pos = pos - 1'b1;
      end
      acc += longint'(1) <<< (FRAC_BITS - 1);   // round half up
      y = acc >>> FRAC_BITS;
      r.sat = 1'b0;
      if (y > Q_MAX) begin
        y     = Q_MAX;
        r.sat = 1'b1;
      end else if (y < Q_MIN) begin
        y     = Q_MIN;
        r.sat = 1'b1;
      end
      r.value = y[SAMPLE_WIDTH-1:0];
      return r;
    endfunction

    function void note_item(kind_t k, logic signed [SAMPLE_WIDTH-1:0] smp,
                            logic [COEF_IDX_W-1:0] idx,
                            logic signed [SAMPLE_WIDTH-1:0] cv);
      fir_result_t r;
      accepted++;
      case (k)
        KIND_LOAD: begin
          if (idx < MAX_TAPS) coef_mem[idx] = cv;
        end
        KIND_PUSH: begin
          hist[wr_ptr] = smp;
          wr_ptr       = wr_ptr + 1'b1;
        end
        KIND_CLEAR: begin
          foreach (hist[i]) hist[i] = '0;
          wr_ptr = '0;
        end
        default: begin
          r = filter_output();
          computes++;
          if (r.sat) sat_seen++;
          pending_q.push_back(r);
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check(logic [SAMPLE_WIDTH-1:0] value, logic sat);
      fir_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("output %0d with no compute pending", $signed(value)));
        return;
      end
      e = pending_q.pop_front();
      if (value !== e.value)
        report($sformatf("filtered_sample got %0d want %0d",
                         $signed(value), $signed(e.value)));
      if (sat !== e.sat)
        report($sformatf("saturated got %b want %b", sat, e.sat));
    endtask

    task flush_check();
      while (pending_q.size() > 0) begin
        void'(pending_q.pop_front());
        report("compute output never arrived");
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // sample_in, coef_index, coef_value
  logic [KIND_W-1:0]      s_tuser   = KIND_LOAD;  // kind
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // filtered_sample
  logic                   m_tuser;          // saturated
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [TAP_CNT_W-1:0]   cfg_data  = '0;   // tap_count

  always #10 clk = ~clk;

  fir_filter_ring_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fir_scoreboard sb = new();

  // idle_mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int                   idle_mode    = 0;
  logic [MAX_TAPS-1:0]  coef_loaded  = '0;   // computes never touch unloaded taps
  int                   stall_cycles = 0;
  int                   n_cfg_writes = 0;

  // receiver back-pressure
  always @(posedge clk) begin
    case (idle_mode)
      2:       m_tready <= ($urandom_range(0, 99) >= 73);
      3:       m_tready <= ($urandom_range(0, 99) >= 33);
      default: m_tready <= 1'b1;
    endcase
  end

  // result monitor: values read here are the ones present at the edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check(m_tdata[SAMPLE_WIDTH-1:0], m_tuser);
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL fir_filter_ring_buffer");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic bit sender_idles();
    case (idle_mode)
      1:       return $urandom_range(0, 99) < 73;
      3:       return $urandom_range(0, 99) < 33;
      default: return 1'b0;
    endcase
  endfunction

  // Q1.15 word: extremes, small magnitudes or anything
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'sh0001;
          default: return 16'shFFFF;
        endcase
      end
      1:       return SAMPLE_WIDTH'(int'($urandom_range(0, 1023)) - 512);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_item(kind_t k, logic signed [SAMPLE_WIDTH-1:0] smp,
                           logic [COEF_IDX_W-1:0] idx,
                           logic signed [SAMPLE_WIDTH-1:0] cv);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[SMP_LSB +: SAMPLE_WIDTH] = smp;
    word[IDX_LSB +: COEF_IDX_W]   = idx;
    word[CV_LSB  +: SAMPLE_WIDTH] = cv;
    while (sender_idles()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= k;
    do @(posedge clk); while (!s_tready);
    sb.note_item(k, smp, idx, cv);
    if (k == KIND_LOAD) coef_loaded[idx] = 1'b1;
  endtask

  // stop sending and let every pending output come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_taps(logic [TAP_CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_taps(v);
    n_cfg_writes++;
  endtask

  task automatic random_item(bit clears_on);
    int                             r;
    int                             n;
    bit                             missing;
    kind_t                          k;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [SAMPLE_WIDTH-1:0] cv;
    logic [COEF_IDX_W-1:0]          idx;
    r   = $urandom_range(0, 99);
    smp = pick_word();
    cv  = pick_word();
    idx = COEF_IDX_W'($urandom_range(0, MAX_TAPS - 1));
    if (r < 40)                      k = KIND_PUSH;
    else if (r < 68)                 k = KIND_COMPUTE;
    else if (r < 97 || !clears_on)   k = KIND_LOAD;
    else                             k = KIND_CLEAR;
    // a compute over a tap with no coefficient yet becomes that tap's load
    if (k == KIND_COMPUTE) begin
      n       = sb.eff_taps();
      missing = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!missing && !coef_loaded[i]) begin
          missing = 1'b1;
          k       = KIND_LOAD;
          idx     = COEF_IDX_W'(i);
        end
      end
    end
    send_item(k, smp, idx, cv);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  // tap settings per phase: small and mid values, zero, the built size, above it, and the 7-bit max
  int unsigned phase_taps [N_PHASES] = '{3, 0, 16, 1, 64, 127, 40, 65, 2, 64};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: two taps, Q1.15 corners
    write_taps(7'd2);
    send_item(KIND_LOAD,    16'sh0000, 6'd0,  16'sh7FFF);
    send_item(KIND_LOAD,    16'sh0000, 6'd1,  16'sh8000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // empty history
    send_item(KIND_PUSH,    16'sh7FFF, 6'd0,  16'sh0000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // max * max
    send_item(KIND_PUSH,    16'sh8000, 6'd0,  16'sh0000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // clamps low
    send_item(KIND_PUSH,    16'sh8000, 6'd0,  16'sh0000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);
    send_item(KIND_LOAD,    16'sh0000, 6'd0,  16'sh8000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // -1 * -1 twice, clamps high
    send_item(KIND_LOAD,    16'sh0000, 6'd63, 16'sh7FFF);  // top tap index
    send_item(KIND_CLEAR,   16'sh7FFF, 6'd0,  16'sh7FFF);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // cleared history
    send_item(KIND_PUSH,    16'sh0001, 6'd0,  16'sh0000);
    send_item(KIND_LOAD,    16'sh0000, 6'd0,  16'sh4000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // +1/2 LSB rounds up
    send_item(KIND_LOAD,    16'sh0000, 6'd0,  16'shC000);
    send_item(KIND_COMPUTE, 16'sh0000, 6'd0,  16'sh0000);  // -1/2 LSB rounds to 0

    // random phases
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      idle_mode = 0;
      write_taps(TAP_CNT_W'(phase_taps[p]));
      idle_mode = p % 4;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off until all outputs are back, mid-phase
        if (p % 3 == 1 && i == PHASE_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (sb.pending() > 0);
        end
        random_item(p % 3 == 0);
      end
    end

    drain();
    sb.flush_check();
    $display("Ran %0d items over %0d tap settings: %0d outputs checked, %0d saturated.",
             sb.accepted, n_cfg_writes, sb.checked, sb.sat_seen);
    if (sb.errors == 0) begin
      $display("PASS fir_filter_ring_buffer");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL fir_filter_ring_buffer");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fir_pkg.sv
design/fir_ram.sv
design/fir_front.sv
design/fir_back.sv
design/fir_filter_ring_buffer.sv
design/fir_checker.sv
sim/tb_fir_filter_ring_buffer.sv
